// ===== sv/pidm_pkg.sv =====
// Shared types, constants and codes of the PCI ID database matcher.
package pidm_pkg;

   localparam int LINE_CHUNK_DEF    = 255;
   localparam int POSITION_BITS_DEF = 24;
   localparam int QUEUE_DEPTH       = 4;
   localparam int ID_W              = 16;
   localparam int NAME_POS_W        = 24;
   localparam int POS_MAX_W         = 32;
   localparam int CSR_DATA_W        = 16;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_CLASS = 8'h43;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_ORDER = 2'd1;
   localparam status_type STATUS_HEX   = 2'd2;

   typedef enum logic [1:0] {
      REG_WANTED_VENDOR,
      REG_WANTED_DEVICE,
      REG_WANTED_SUB_VENDOR,
      REG_WANTED_SUB_DEVICE
   } csr_index_type;

   typedef enum logic [2:0] {
      LINE_SKIP,
      LINE_CLASS,
      LINE_VENDOR,
      LINE_DEVICE,
      LINE_SUB
   } line_kind_type;

   typedef struct packed {
      line_kind_type    kind;
      logic             bad_hex;
      logic             last;
      logic [ID_W-1:0]  hex_a;
      logic [ID_W-1:0]  hex_b;
   } line_info_type;

   typedef struct packed {
      logic [ID_W-1:0] vendor;
      logic [ID_W-1:0] device;
      logic [ID_W-1:0] sub_vendor;
      logic [ID_W-1:0] sub_device;
   } wanted_type;

endpackage

// ===== sv/pidm_channels.sv =====
// Handshake channels of the PCI ID database matcher: text in, result out, register writes.
interface pidm_req_if;
   import pidm_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;
   modport source (output valid, text_byte, final_byte, input ready);
   modport sink (input valid, text_byte, final_byte, output ready);
endinterface

interface pidm_rsp_if;
   import pidm_pkg::*;
   logic                  valid;
   logic                  ready;
   status_type            status;
   logic                  vendor_hit;
   logic                  device_hit;
   logic                  subsystem_hit;
   logic [NAME_POS_W-1:0] vendor_name_pos;
   logic [NAME_POS_W-1:0] device_name_pos;
   logic [NAME_POS_W-1:0] subsystem_name_pos;
   modport source (output valid, status, vendor_hit, device_hit, subsystem_hit,
                   vendor_name_pos, device_name_pos, subsystem_name_pos, input ready);
   modport sink (input valid, status, vendor_hit, device_hit, subsystem_hit,
                 vendor_name_pos, device_name_pos, subsystem_name_pos, output ready);
endinterface

interface pidm_csr_if;
   import pidm_pkg::*;
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/pidm_front.sv =====
// Line assembler: takes text bytes, gathers hex fields and flags, classifies each finished line.
module pidm_front #(
   parameter int LINE_CHUNK    = pidm_pkg::LINE_CHUNK_DEF,
   parameter int POSITION_BITS = pidm_pkg::POSITION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   pidm_req_if.sink                  req_ch,
   output logic                      line_valid,
   input  logic                      line_ready,
   output pidm_pkg::line_info_type   line_info,
   output logic [POSITION_BITS-1:0]  line_pos
);
   import pidm_pkg::*;

   localparam int COL_W = $clog2(LINE_CHUNK + 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_CHUNK);

   logic [COL_W-1:0]         col_ff, col_in, col_inc;
   logic [POSITION_BITS-1:0] bpos_ff, bpos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [7:0]               c0_ff, c0_in, c1_ff, c1_in;
   logic                     nul_ff, nul_in, ns_ff, ns_in, he_ff, he_in;
   logic [ID_W-1:0]          hexa_ff, hexa_in, hexb_ff, hexb_in;
   logic [ID_W-1:0]          a_base, b_base;
   logic                     first, nul_base, ns_base, he_base;
   logic                     blank, in_a, in_b, line_end, accept;
   logic [7:0]               ch;
   logic [4:0]               dig;
   logic [COL_W-1:0]         need;

   // bit 4: valid digit, bits 3:0: value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   assign req_ch.ready = line_ready;
   assign accept       = req_ch.valid && line_ready;
   assign line_valid   = req_ch.valid && line_end;

   always_comb begin
      ch       = req_ch.text_byte;
      first    = (col_ff == '0);
      c0_in    = first ? ch : c0_ff;
      c1_in    = first ? 8'h00 : ((col_ff == COL_W'(1)) ? ch : c1_ff);
      nul_base = !first && nul_ff;
      ns_base  = !first && ns_ff;
      he_base  = !first && he_ff;
      a_base   = first ? '0 : hexa_ff;
      b_base   = first ? '0 : hexb_ff;
      start_in = first ? bpos_ff : start_ff;

      blank  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
      nul_in = nul_base || (ch == CH_NUL);
      ns_in  = ns_base || (!nul_base && ch != CH_NUL && !blank);

      // first hex field starts at column 0, 1 or 2 after leading tabs
      if (c0_in != CH_TAB) begin
         in_a = col_ff < COL_W'(4);
      end else if (c1_in != CH_TAB) begin
         in_a = col_ff >= COL_W'(1) && col_ff < COL_W'(5);
      end else begin
         in_a = col_ff >= COL_W'(2) && col_ff < COL_W'(6);
      end
      in_b = (c0_in == CH_TAB) && (c1_in == CH_TAB) &&
             col_ff >= COL_W'(7) && col_ff < COL_W'(11);

      dig     = hex_digit(ch);
      hexa_in = (in_a && dig[4]) ? {a_base[ID_W-5:0], dig[3:0]} : a_base;
      hexb_in = (in_b && dig[4]) ? {b_base[ID_W-5:0], dig[3:0]} : b_base;
      he_in   = he_base || ((in_a || in_b) && !dig[4]);

      col_inc  = col_ff + COL_W'(1);
      line_end = (ch == CH_NL) || (col_inc >= COL_LAST) || req_ch.final_byte;
      col_in   = line_end ? '0 : col_inc;
      bpos_in  = req_ch.final_byte ? '0 : bpos_ff + POSITION_BITS'(1);

      if (!ns_in || c0_in == CH_HASH) begin
         line_info.kind = LINE_SKIP;
         need = COL_W'(4);
      end else if (c0_in == CH_TAB) begin
         line_info.kind = (c1_in == CH_TAB) ? LINE_SUB : LINE_DEVICE;
         need = (c1_in == CH_TAB) ? COL_W'(11) : COL_W'(5);
      end else if (c0_in == CH_CLASS) begin
         line_info.kind = LINE_CLASS;
         need = COL_W'(4);
      end else begin
         line_info.kind = LINE_VENDOR;
         need = COL_W'(4);
      end
      line_info.bad_hex = he_in || (col_inc < need);
      line_info.last    = req_ch.final_byte;
      line_info.hex_a   = hexa_in;
      line_info.hex_b   = hexb_in;
      line_pos          = start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         bpos_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         bpos_ff <= bpos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff <= start_in;
         c0_ff    <= c0_in;
         c1_ff    <= c1_in;
         nul_ff   <= nul_in;
         ns_ff    <= ns_in;
         he_ff    <= he_in;
         hexa_ff  <= hexa_in;
         hexb_ff  <= hexb_in;
      end
   end

endmodule

// ===== sv/pidm_queue.sv =====
// Small first-in first-out queue of line records between the assembler and the matcher.
module pidm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pidm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   always_comb begin
      in_ready  = (count_ff != CW'(DEPTH));
      out_valid = (count_ff != '0);
      out_data  = slot_ff[rd_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

endmodule

// ===== sv/pidm_back.sv =====
// Matcher: applies each line record to the search state and registers the result item.
module pidm_back #(
   parameter int POSITION_BITS = pidm_pkg::POSITION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      line_valid,
   output logic                      line_ready,
   input  pidm_pkg::line_info_type   line_info,
   input  logic [POSITION_BITS-1:0]  line_pos,
   input  pidm_pkg::wanted_type      wanted,
   pidm_rsp_if.source                rsp_ch
);
   import pidm_pkg::*;

   logic                     vhit_ff, vhit_in, dhit_ff, dhit_in, shit_ff, shit_in;
   logic                     dset_ff, dset_in, sset_ff, sset_in, class_ff, class_in;
   status_type               err_ff, err_in;
   logic                     cv_vendor_ff, cv_vendor_in, cv_device_ff, cv_device_in;
   logic                     cv_sub_ff, cv_sub_in;
   logic [ID_W-1:0]          cur_vendor_ff, cur_vendor_in, cur_device_ff, cur_device_in;
   logic [ID_W-1:0]          cur_sv_ff, cur_sv_in, cur_sd_ff, cur_sd_in;
   logic [POSITION_BITS-1:0] found_v_ff, found_v_in, found_d_ff, found_d_in;
   logic [POSITION_BITS-1:0] found_s_ff, found_s_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff;
   logic                     vhit_out_ff, dhit_out_ff, shit_out_ff;
   logic [NAME_POS_W-1:0]    vpos_ff, dpos_ff, spos_ff;
   logic                     settled, do_match, pop, pop_last;

   function automatic logic [NAME_POS_W-1:0] name_pos(input logic hit,
                                                     input logic [POSITION_BITS-1:0] p);
      logic [POS_MAX_W-1:0] wide;
      wide = POS_MAX_W'(p);
      return hit ? wide[NAME_POS_W-1:0] : '0;
   endfunction

   assign line_ready = !line_info.last || !rsp_valid_ff || rsp_ch.ready;
   assign pop        = line_valid && line_ready;
   assign pop_last   = pop && line_info.last;

   always_comb begin
      vhit_in       = vhit_ff;
      dhit_in       = dhit_ff;
      shit_in       = shit_ff;
      dset_in       = dset_ff;
      sset_in       = sset_ff;
      class_in      = class_ff;
      err_in        = err_ff;
      cv_vendor_in  = cv_vendor_ff;
      cv_device_in  = cv_device_ff;
      cv_sub_in     = cv_sub_ff;
      cur_vendor_in = cur_vendor_ff;
      cur_device_in = cur_device_ff;
      cur_sv_in     = cur_sv_ff;
      cur_sd_in     = cur_sd_ff;
      found_v_in    = found_v_ff;
      found_d_in    = found_d_ff;
      found_s_in    = found_s_ff;
      do_match      = 1'b0;
      settled       = vhit_ff && (dhit_ff || dset_ff) && (shit_ff || sset_ff);

      if (err_ff == STATUS_OK && !settled) begin
         unique case (line_info.kind)
            LINE_SKIP: begin
            end
            LINE_CLASS: begin
               class_in = 1'b1;
            end
            LINE_VENDOR: begin
               if (!vhit_ff) begin
                  class_in = 1'b0;
                  if (line_info.bad_hex) begin
                     err_in = STATUS_HEX;
                  end else begin
                     cur_vendor_in = line_info.hex_a;
                     cv_vendor_in  = 1'b1;
                     cv_device_in  = 1'b0;
                     cv_sub_in     = 1'b0;
                     found_v_in    = line_pos + POSITION_BITS'(5);
                     do_match      = 1'b1;
                  end
               end else begin
                  // vendor already found: the rest of its block is over
                  dset_in  = 1'b1;
                  sset_in  = 1'b1;
                  do_match = 1'b1;
               end
            end
            LINE_DEVICE: begin
               if (class_ff) begin
               end else if (!cv_vendor_ff) begin
                  err_in = STATUS_ORDER;
               end else if (!dhit_ff) begin
                  if (line_info.bad_hex) begin
                     err_in = STATUS_HEX;
                  end else begin
                     cur_device_in = line_info.hex_a;
                     cv_device_in  = 1'b1;
                     cv_sub_in     = 1'b0;
                     found_d_in    = line_pos + POSITION_BITS'(6);
                     do_match      = 1'b1;
                  end
               end else begin
                  sset_in  = 1'b1;
                  do_match = 1'b1;
               end
            end
            LINE_SUB: begin
               if (class_ff) begin
               end else if (!cv_vendor_ff) begin
                  err_in = STATUS_ORDER;
               end else if (!(shit_ff || sset_ff)) begin
                  if (!cv_device_ff) begin
                     err_in = STATUS_ORDER;
                  end else if (line_info.bad_hex) begin
                     err_in = STATUS_HEX;
                  end else begin
                     cur_sv_in  = line_info.hex_a;
                     cur_sd_in  = line_info.hex_b;
                     cv_sub_in  = 1'b1;
                     found_s_in = line_pos + POSITION_BITS'(12);
                     do_match   = 1'b1;
                  end
               end else begin
                  do_match = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (do_match && !class_in && cv_vendor_in && cur_vendor_in == wanted.vendor) begin
         vhit_in = 1'b1;
         if (cv_device_in && cur_device_in == wanted.device) begin
            dhit_in = 1'b1;
            if (cv_sub_in && cur_sv_in == wanted.sub_vendor &&
                cur_sd_in == wanted.sub_device) begin
               shit_in = 1'b1;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (pop_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // search state starts over after the final line of a file
   always_ff @(posedge clock) begin
      if (reset) begin
         vhit_ff      <= 1'b0;
         dhit_ff      <= 1'b0;
         shit_ff      <= 1'b0;
         dset_ff      <= 1'b0;
         sset_ff      <= 1'b0;
         class_ff     <= 1'b0;
         err_ff       <= STATUS_OK;
         cv_vendor_ff <= 1'b0;
         cv_device_ff <= 1'b0;
         cv_sub_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop_last) begin
            vhit_ff      <= 1'b0;
            dhit_ff      <= 1'b0;
            shit_ff      <= 1'b0;
            dset_ff      <= 1'b0;
            sset_ff      <= 1'b0;
            class_ff     <= 1'b0;
            err_ff       <= STATUS_OK;
            cv_vendor_ff <= 1'b0;
            cv_device_ff <= 1'b0;
            cv_sub_ff    <= 1'b0;
         end else if (pop) begin
            vhit_ff      <= vhit_in;
            dhit_ff      <= dhit_in;
            shit_ff      <= shit_in;
            dset_ff      <= dset_in;
            sset_ff      <= sset_in;
            class_ff     <= class_in;
            err_ff       <= err_in;
            cv_vendor_ff <= cv_vendor_in;
            cv_device_ff <= cv_device_in;
            cv_sub_ff    <= cv_sub_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_vendor_ff <= cur_vendor_in;
         cur_device_ff <= cur_device_in;
         cur_sv_ff     <= cur_sv_in;
         cur_sd_ff     <= cur_sd_in;
         found_v_ff    <= found_v_in;
         found_d_ff    <= found_d_in;
         found_s_ff    <= found_s_in;
      end
      if (pop_last) begin
         status_ff   <= err_in;
         vhit_out_ff <= vhit_in;
         dhit_out_ff <= dhit_in;
         shit_out_ff <= shit_in;
         vpos_ff     <= name_pos(vhit_in, found_v_in);
         dpos_ff     <= name_pos(dhit_in, found_d_in);
         spos_ff     <= name_pos(shit_in, found_s_in);
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.status             = status_ff;
   assign rsp_ch.vendor_hit         = vhit_out_ff;
   assign rsp_ch.device_hit         = dhit_out_ff;
   assign rsp_ch.subsystem_hit      = shit_out_ff;
   assign rsp_ch.vendor_name_pos    = vpos_ff;
   assign rsp_ch.device_name_pos    = dpos_ff;
   assign rsp_ch.subsystem_name_pos = spos_ff;

endmodule

// ===== sv/pci_id_database_matcher_top.sv =====
// Top level of the PCI ID database matcher: register bank, line assembler, queue, matcher.
//
//   channel  direction  carries                                   accepted when
//   req_ch   in         text_byte, final_byte                     valid && ready
//   rsp_ch   out        status, hit bits, three name offsets      valid && ready
//   csr_ch   in         index, data (wanted IDs)                  valid && ready
//
// One text byte per cycle unless the queue is full; the assembler registers its line state.
// Each finished line becomes one record in a 4-entry queue; the matcher retires one per cycle
// unless it holds a final record. The result item is registered as the final byte's record
// leaves the queue. req_ch stalls only when the queue is full: the matcher holds
// a final record while an earlier result still waits in the output register.
// Reset is synchronous; there is no clearing pass. csr_ch is always ready.
module pci_id_database_matcher_top #(
   parameter int LINE_CHUNK    = pidm_pkg::LINE_CHUNK_DEF,
   parameter int POSITION_BITS = pidm_pkg::POSITION_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   pidm_req_if.sink    req_ch,
   pidm_rsp_if.source  rsp_ch,
   pidm_csr_if.sink    csr_ch
);
   import pidm_pkg::*;

   localparam int REC_W = $bits(line_info_type) + POSITION_BITS;

   wanted_type               wanted_ff;
   logic                     f_valid, f_ready, b_valid, b_ready;
   line_info_type            f_info, b_info;
   logic [POSITION_BITS-1:0] f_pos, b_pos;
   logic [REC_W-1:0]         q_out;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_WANTED_VENDOR:     wanted_ff.vendor     <= csr_ch.data;
            REG_WANTED_DEVICE:     wanted_ff.device     <= csr_ch.data;
            REG_WANTED_SUB_VENDOR: wanted_ff.sub_vendor <= csr_ch.data;
            REG_WANTED_SUB_DEVICE: wanted_ff.sub_device <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   pidm_front #(
      .LINE_CHUNK    (LINE_CHUNK),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .line_valid (f_valid),
      .line_ready (f_ready),
      .line_info  (f_info),
      .line_pos   (f_pos)
   );

   pidm_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_info, f_pos}),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out)
   );

   assign b_info = line_info_type'(q_out[REC_W-1:POSITION_BITS]);
   assign b_pos  = q_out[POSITION_BITS-1:0];

   pidm_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .line_valid (b_valid),
      .line_ready (b_ready),
      .line_info  (b_info),
      .line_pos   (b_pos),
      .wanted     (wanted_ff),
      .rsp_ch     (rsp_ch)
   );

`ifndef ASSERT_OFF
   // a final byte always closes its line into the queue
   a_final_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.final_byte) |-> (f_valid && f_ready))
      else $error("final byte accepted without a line record");

   // a result item comes only from a final record leaving the queue
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(b_valid && b_ready && b_info.last))
      else $error("result item without a final record");

   // hits nest: device under vendor, subsystem under device
   a_hit_nesting: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((!rsp_ch.device_hit || rsp_ch.vendor_hit) &&
                        (!rsp_ch.subsystem_hit || rsp_ch.device_hit)))
      else $error("hit bits out of order");
`endif

endmodule

// ===== sim/pidm_lookup_checker.sv =====
// Lookup checker for the PCI ID database matcher: tracks the text stream, predicts and compares.
module pidm_lookup_checker (
   input  logic clock,
   input  logic reset,
   pidm_req_if  text_ch,
   pidm_rsp_if  lookup_ch,
   pidm_csr_if  reg_ch,
   output int   fail_count,
   output int   open_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pidm_pkg::*;

   typedef struct {
      status_type            status;
      logic                  vendor_hit;
      logic                  device_hit;
      logic                  subsystem_hit;
      logic [NAME_POS_W-1:0] vendor_pos;
      logic [NAME_POS_W-1:0] device_pos;
      logic [NAME_POS_W-1:0] subsystem_pos;
   } lookup_type;

   lookup_type lookups_due[$];
   wanted_type wanted;
   int         errors;

   // scan state of the current document
   logic [NAME_POS_W-1:0] text_pos;
   logic [NAME_POS_W-1:0] line_base;
   int                    line_len;
   logic [7:0]            first_ch;
   logic [7:0]            second_ch;
   logic [ID_W-1:0]       id_a;
   logic [ID_W-1:0]       id_b;
   logic                  seen_visible;
   logic                  bad_digit;
   logic                  seen_nul;
   logic                  got_vendor;
   logic                  got_device;
   logic                  got_sub;
   logic                  device_closed;
   logic                  sub_closed;
   logic                  in_class;
   logic [NAME_POS_W-1:0] vendor_at;
   logic [NAME_POS_W-1:0] device_at;
   logic [NAME_POS_W-1:0] sub_at;
   status_type            scan_status;
   logic                  vendor_open;
   logic                  device_open;
   logic                  sub_open;
   logic [ID_W-1:0]       cur_vendor;
   logic [ID_W-1:0]       cur_device;
   logic [ID_W-1:0]       cur_sub_vendor;
   logic [ID_W-1:0]       cur_sub_device;

   task automatic start_document();
      text_pos = '0;
      line_base = '0;
      line_len = 0;
      first_ch = '0;
      second_ch = '0;
      id_a = '0;
      id_b = '0;
      {seen_visible, bad_digit, seen_nul} = '0;
      {got_vendor, got_device, got_sub, device_closed, sub_closed, in_class} = '0;
      vendor_at = '0;
      device_at = '0;
      sub_at = '0;
      scan_status = STATUS_OK;
      {vendor_open, device_open, sub_open} = '0;
      cur_vendor = '0;
      cur_device = '0;
      cur_sub_vendor = '0;
      cur_sub_device = '0;
   endtask

   function automatic bit is_space(logic [7:0] ch);
      return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
   endfunction

   function automatic bit search_done();
      return got_vendor && (got_device || device_closed) && (got_sub || sub_closed);
   endfunction

   task automatic add_digit(input logic [7:0] ch, inout logic [ID_W-1:0] acc);
      logic [3:0] d;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         d = ch[3:0];
      end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
         d = ch[3:0] + 4'd9;
      end else begin
         bad_digit = 1'b1;
         return;
      end
      acc = {acc[ID_W-5:0], d};
   endtask

   task automatic close_line();
      if (scan_status != STATUS_OK || search_done()) return;
      if (!seen_visible || first_ch == CH_HASH) return;

      if (first_ch == CH_TAB) begin
         if (in_class) return;
         if (!vendor_open) begin
            scan_status = STATUS_ORDER;
            return;
         end
         if (second_ch == CH_TAB) begin
            if (!(got_sub || sub_closed)) begin
               if (!device_open) begin
                  scan_status = STATUS_ORDER;
                  return;
               end
               if (bad_digit || line_len < 11) begin
                  scan_status = STATUS_HEX;
                  return;
               end
               cur_sub_vendor = id_a;
               cur_sub_device = id_b;
               sub_open = 1'b1;
               sub_at = line_base + NAME_POS_W'(12);
            end
         end else if (!got_device) begin
            if (bad_digit || line_len < 5) begin
               scan_status = STATUS_HEX;
               return;
            end
            cur_device = id_a;
            device_open = 1'b1;
            sub_open = 1'b0;
            device_at = line_base + NAME_POS_W'(6);
         end else begin
            sub_closed = 1'b1;
         end
      end else if (first_ch == CH_CLASS) begin
         in_class = 1'b1;
         return;
      end else if (!got_vendor) begin
         in_class = 1'b0;
         if (bad_digit || line_len < 4) begin
            scan_status = STATUS_HEX;
            return;
         end
         cur_vendor = id_a;
         vendor_open = 1'b1;
         device_open = 1'b0;
         sub_open = 1'b0;
         vendor_at = line_base + NAME_POS_W'(5);
      end else begin
         device_closed = 1'b1;
         sub_closed = 1'b1;
      end

      if (in_class) return;
      if (vendor_open && cur_vendor == wanted.vendor) begin
         got_vendor = 1'b1;
         if (device_open && cur_device == wanted.device) begin
            got_device = 1'b1;
            if (sub_open && cur_sub_vendor == wanted.sub_vendor &&
                cur_sub_device == wanted.sub_device)
               got_sub = 1'b1;
         end
      end
   endtask

   task automatic take_byte(input logic [7:0] ch, input logic fin);
      int col;
      int start_a;
      lookup_type res;
      col = line_len;
      if (col == 0) begin
         line_base = text_pos;
         id_a = '0;
         id_b = '0;
         {seen_visible, bad_digit, seen_nul} = '0;
         first_ch = ch;
         second_ch = '0;
      end else if (col == 1) begin
         second_ch = ch;
      end

      // a NUL hides the rest of the line
      if (!seen_nul) begin
         if (ch == CH_NUL) seen_nul = 1'b1;
         else if (!is_space(ch)) seen_visible = 1'b1;
      end

      if (first_ch != CH_TAB) start_a = 0;
      else if (col >= 1) start_a = (second_ch != CH_TAB) ? 1 : 2;
      else start_a = 16;
      if (col >= start_a && col < start_a + 4) add_digit(ch, id_a);
      if (first_ch == CH_TAB && second_ch == CH_TAB && col >= 7 && col < 11)
         add_digit(ch, id_b);

      line_len = col + 1;
      text_pos = text_pos + 1'b1;

      if (ch == CH_NL || line_len >= LINE_CHUNK_DEF || fin) begin
         close_line();
         line_len = 0;
         first_ch = '0;
         second_ch = '0;
         {seen_visible, bad_digit, seen_nul} = '0;
      end

      if (fin) begin
         res.status = scan_status;
         res.vendor_hit = got_vendor;
         res.device_hit = got_device;
         res.subsystem_hit = got_sub;
         res.vendor_pos = got_vendor ? vendor_at : '0;
         res.device_pos = got_device ? device_at : '0;
         res.subsystem_pos = got_sub ? sub_at : '0;
         lookups_due.push_back(res);
         start_document();
      end
   endtask

   task automatic check_field(input string field, input logic [NAME_POS_W-1:0] want,
                              input logic [NAME_POS_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      lookup_type want;
      if (reset) begin
         start_document();
         wanted = '0;
         lookups_due.delete();
         errors = 0;
      end else begin
         if (lookup_ch.valid && lookup_ch.ready) begin
            if (lookups_due.size() == 0) begin
               $error("result item with no lookup pending, status %0d", lookup_ch.status);
               errors++;
            end else begin
               want = lookups_due.pop_front();
               check_field("status", NAME_POS_W'(want.status),
                           NAME_POS_W'(lookup_ch.status));
               check_field("vendor_hit", NAME_POS_W'(want.vendor_hit),
                           NAME_POS_W'(lookup_ch.vendor_hit));
               check_field("device_hit", NAME_POS_W'(want.device_hit),
                           NAME_POS_W'(lookup_ch.device_hit));
               check_field("subsystem_hit", NAME_POS_W'(want.subsystem_hit),
                           NAME_POS_W'(lookup_ch.subsystem_hit));
               check_field("vendor_name_pos", want.vendor_pos, lookup_ch.vendor_name_pos);
               check_field("device_name_pos", want.device_pos, lookup_ch.device_name_pos);
               check_field("subsystem_name_pos", want.subsystem_pos,
                           lookup_ch.subsystem_name_pos);
            end
         end
         if (reg_ch.valid && reg_ch.ready) begin
            case (reg_ch.index)
               REG_WANTED_VENDOR:     wanted.vendor = reg_ch.data;
               REG_WANTED_DEVICE:     wanted.device = reg_ch.data;
               REG_WANTED_SUB_VENDOR: wanted.sub_vendor = reg_ch.data;
               REG_WANTED_SUB_DEVICE: wanted.sub_device = reg_ch.data;
               default: ;
            endcase
         end
         if (text_ch.valid && text_ch.ready)
            take_byte(text_ch.text_byte, text_ch.final_byte);
      end
      fail_count <= errors;
      open_count <= lookups_due.size();
   end

endmodule

// ===== sim/pci_id_database_matcher_top_tb.sv =====
// Testbench top of the PCI ID database matcher: clock, reset, text and register stimulus, verdict.
module pci_id_database_matcher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pidm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pidm_req_if text_ch();
   pidm_rsp_if lookup_ch();
   pidm_csr_if reg_ch();

   int fail_count;
   int open_count;

   logic [7:0] doc_text[$];
   wanted_type wanted_ids;
   int         bytes_sent;
   int         files_sent;
   bit         text_idling;
   int         line_no;
   int         flaw_line;

   pci_id_database_matcher_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (text_ch),
      .rsp_ch (lookup_ch),
      .csr_ch (reg_ch)
   );

   pidm_lookup_checker i_lookup_checker (
      .clock      (clock),
      .reset      (reset),
      .text_ch    (text_ch),
      .lookup_ch  (lookup_ch),
      .reg_ch     (reg_ch),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stalls, calm stretches, and long hold-offs to back up the queue
   initial begin
      int stall;
      int taken;
      bit calm;
      taken = 0;
      calm = 1'b0;
      lookup_ch.ready = 1'b0;
      forever begin
         if (taken % 12 == 0) calm = ($urandom_range(0, 2) == 0);
         stall = calm ? 0 : $urandom_range(0, 8);
         if (taken == 4 || taken == 30) stall = 1500;
         if (stall > 0) begin
            lookup_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         lookup_ch.ready <= 1'b1;
         do @(posedge clock); while (!lookup_ch.valid);
         taken++;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = text_idling ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         text_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      text_ch.valid <= 1'b1;
      text_ch.text_byte <= b;
      text_ch.final_byte <= fin;
      do @(posedge clock); while (!text_ch.ready);
      bytes_sent++;
   endtask

   task automatic send_file();
      text_idling = ($urandom_range(0, 3) != 0);
      foreach (doc_text[i]) send_byte(doc_text[i], i == doc_text.size() - 1);
      doc_text.delete();
      files_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [ID_W-1:0] value);
      reg_ch.valid <= 1'b1;
      reg_ch.index <= idx;
      reg_ch.data <= value;
      do @(posedge clock); while (!reg_ch.ready);
   endtask

   // change the wanted IDs only once every lookup has come back
   task automatic set_wanted(input wanted_type w);
      text_ch.valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (4) @(posedge clock);
      write_reg(REG_WANTED_VENDOR, w.vendor);
      write_reg(REG_WANTED_DEVICE, w.device);
      write_reg(REG_WANTED_SUB_VENDOR, w.sub_vendor);
      write_reg(REG_WANTED_SUB_DEVICE, w.sub_device);
      reg_ch.valid <= 1'b0;
      wanted_ids = w;
   endtask

   function automatic logic [ID_W-1:0] random_reg();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return ID_W'($urandom);
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] target);
      case ($urandom_range(0, 3))
         0, 1: return target;
         2: return ID_W'($urandom);
         default: return target ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      if (d < 10) return 8'h30 + d;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 8'd10;
   endfunction

   // non-hex bytes, mostly right at the edges of the digit and letter ranges
   function automatic logic [7:0] non_hex_char();
      case ($urandom_range(0, 7))
         0: return 8'h2F;
         1: return 8'h3A;
         2: return 8'h40;
         3: return 8'h47;
         4: return 8'h67;
         5: return CH_SPACE;
         6: return CH_NUL;
         default: return 8'($urandom_range(8'h80, 8'hFF));
      endcase
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) doc_text.push_back(s[i]);
   endtask

   task automatic put_hex(input logic [ID_W-1:0] v);
      for (int k = 3; k >= 0; k--) doc_text.push_back(hex_char(v[4*k +: 4]));
   endtask

   task automatic put_name();
      logic [7:0] b;
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 19))
            0, 1: b = 8'($urandom_range(8'h80, 8'hFF));
            2: b = CH_NUL;
            3: b = CH_SPACE;
            default: b = 8'($urandom_range(8'h21, 8'h7E));
         endcase
         doc_text.push_back(b);
      end
   endtask

   task automatic emit_line(input line_kind_type kind);
      case (kind)
         LINE_VENDOR: begin
            put_hex(pick_id(wanted_ids.vendor));
            put_text(" ");
         end
         LINE_DEVICE: begin
            put_text("\t");
            put_hex(pick_id(wanted_ids.device));
            put_text(" ");
         end
         LINE_SUB: begin
            put_text("\t\t");
            put_hex(pick_id(wanted_ids.sub_vendor));
            put_text(" ");
            put_hex(pick_id(wanted_ids.sub_device));
            put_text(" ");
         end
         LINE_CLASS: begin
            put_text("C 02 ");
            put_name();
            put_text("\n\t00 ");
            put_name();
            put_text("\n\t\t01 ");
         end
         default: begin
            // comment, empty, white space only, or hidden behind a NUL
            case ($urandom_range(0, 4))
               0: put_text("#");
               1: ;
               2: put_text(" \t ");
               3: doc_text.push_back(CH_CR);
               default: doc_text.push_back(CH_NUL);
            endcase
         end
      endcase
      put_name();
      doc_text.push_back(CH_NL);
   endtask

   task automatic put_flaw();
      int k;
      k = $urandom_range(1, 3);
      case ($urandom_range(0, 5))
         0: begin
            put_hex(pick_id(wanted_ids.vendor));
            doc_text[doc_text.size() - k] = non_hex_char();
            put_text(" v\n");
         end
         1: begin
            put_hex(pick_id(wanted_ids.vendor));
            repeat (k) void'(doc_text.pop_back());
            put_text("\n");
         end
         2: begin
            put_text("\t");
            put_hex(pick_id(wanted_ids.device));
            doc_text[doc_text.size() - k] = non_hex_char();
            put_text(" d\n");
         end
         3: begin
            put_text("\t\t");
            put_hex(pick_id(wanted_ids.sub_vendor));
            put_text(" ");
            put_hex(pick_id(wanted_ids.sub_device));
            repeat (k) void'(doc_text.pop_back());
            put_text("\n");
         end
         4: emit_line(LINE_SUB);
         default: emit_line(LINE_DEVICE);
      endcase
   endtask

   task automatic next_line(input line_kind_type kind);
      if ($urandom_range(0, 6) == 0) emit_line(LINE_SKIP);
      if (line_no == flaw_line) put_flaw();
      else emit_line(kind);
      line_no++;
   endtask

   task automatic build_catalog(input bit flawed);
      int devices;
      int subs;
      line_no = 0;
      flaw_line = flawed ? $urandom_range(0, 3) : -1;
      repeat ($urandom_range(1, 2)) begin
         next_line(LINE_VENDOR);
         devices = $urandom_range(0, 2);
         repeat (devices) begin
            next_line(LINE_DEVICE);
            subs = $urandom_range(0, 2);
            repeat (subs) next_line(LINE_SUB);
         end
         if ($urandom_range(0, 4) == 0) emit_line(LINE_CLASS);
      end
      // end the file without its last newline now and then
      if ($urandom_range(0, 1) && doc_text.size() > 1 && doc_text[$] == CH_NL)
         void'(doc_text.pop_back());
   endtask

   task automatic build_noise();
      logic [7:0] b;
      repeat ($urandom_range(1, 40)) begin
         case ($urandom_range(0, 7))
            0: b = hex_char(4'($urandom));
            1: b = CH_TAB;
            2: b = CH_NL;
            3: b = CH_SPACE;
            4: b = CH_HASH;
            5: b = CH_CLASS;
            6: b = CH_NUL;
            default: b = 8'($urandom_range(0, 255));
         endcase
         doc_text.push_back(b);
      end
   endtask

   // vendor line longer than one line chunk, so it gets split
   task automatic build_long();
      logic [7:0] b;
      put_hex(wanted_ids.vendor);
      put_text(" ");
      repeat ($urandom_range(250, 300)) begin
         b = 8'($urandom_range(0, 255));
         if (b == CH_NL) b = CH_SPACE;
         doc_text.push_back(b);
      end
      doc_text.push_back(CH_NL);
      emit_line(LINE_DEVICE);
   endtask

   initial begin
      wanted_type w;
      int pick;
      text_ch.valid = 1'b0;
      text_ch.text_byte = '0;
      text_ch.final_byte = 1'b0;
      reg_ch.valid = 1'b0;
      reg_ch.index = REG_WANTED_VENDOR;
      reg_ch.data = '0;
      wanted_ids = '0;
      bytes_sent = 0;
      files_sent = 0;
      text_idling = 1'b1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: all-zero IDs
      put_text("0000 a\n\t0000 b\n\t\t0000 0000 c\n");
      send_file();
      put_text("\t0000 d\n");
      send_file();
      doc_text.push_back(8'hFF);
      send_file();

      w.vendor = '1;
      w.device = '1;
      w.sub_vendor = '1;
      w.sub_device = '1;
      set_wanted(w);
      put_text("FFFF x\n\tffff y\n\t\tFfFf fFFf z");
      send_file();

      while (bytes_sent < 1850) begin
         if (files_sent % 6 == 0) begin
            w.vendor = random_reg();
            w.device = random_reg();
            w.sub_vendor = random_reg();
            w.sub_device = random_reg();
            set_wanted(w);
         end
         pick = $urandom_range(0, 99);
         if (pick < 65) build_catalog(1'b0);
         else if (pick < 82) build_catalog(1'b1);
         else if (pick < 96) build_noise();
         else build_long();
         send_file();
      end

      text_ch.valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
